[sv/wgm_pkg.sv]
// Package for the wildcard glob matcher: transaction payload types, command
// codes, special characters and the ASCII case fold.
// No dependencies.
package wgm_pkg;

   localparam int MAX_PATTERN_DEF = 32;
   localparam int CHAR_BITS_DEF   = 16;
   localparam int CODE_W          = 16;

   localparam logic [31:0] STAR_CHAR  = 32'h0000_002A;
   localparam logic [31:0] QUEST_CHAR = 32'h0000_003F;

   typedef enum logic [1:0] {
      CMD_APPEND  = 2'd0,
      CMD_SUBJECT = 2'd1,
      CMD_END     = 2'd2,
      CMD_CLEAR   = 2'd3
   } wgm_cmd_type;

   typedef struct packed {
      wgm_cmd_type        command;
      logic [CODE_W-1:0]  char_code;
   } wgm_req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } wgm_rsp_type;

   typedef struct packed {
      logic case_sensitive;
   } wgm_csr_type;

   // only a-z map to A-Z; every other code passes unchanged
   function automatic logic [31:0] fold_ascii(input logic [31:0] c);
      logic [31:0] r;
      r = c;
      if (c >= 32'h61 && c <= 32'h7A) begin
         r = c - 32'h20;
      end
      return r;
   endfunction

endpackage

[sv/wgm_chan_if.sv]
// Valid/ready channel carrying one payload struct per transaction.
// Payload types come from wgm_pkg.
interface wgm_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/wildcard_glob_matcher.sv]
// Wildcard glob matcher ('*' and '?') over a stream of pattern and subject
// characters. Depends on wgm_pkg and wgm_chan_if.
//
//   channel  dir  payload                          transaction
//   req_if   in   command, char_code               one command
//   rsp_if   out  matched, pattern_overflow        one per end of subject
//   csr_if   in   case_sensitive                   register write, always ready
//
// One command per cycle sustained while no end of subject waits on rsp_if:
// every command is latched in an input register and then resolved; an end
// of subject moves on into the result register behind rsp_if. All pattern
// positions update at once, the star closure is a log-depth prefix network
// over MAX_PATTERN+1 flags. Synchronous reset clears length, flags and
// case_sensitive; the pattern store is not cleared. A stalled rsp_if holds
// the result; a following end of subject then waits and blocks all behind it.
module wildcard_glob_matcher #(
   parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
   parameter int CHAR_BITS   = wgm_pkg::CHAR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wgm_chan_if.sink    req_if,
   wgm_chan_if.source  rsp_if,
   wgm_chan_if.sink    csr_if
);
   import wgm_pkg::*;

   localparam int NPOS   = MAX_PATTERN + 1;
   localparam int LEN_W  = $clog2(NPOS);
   localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEVELS = $clog2(NPOS);

   // input register
   logic              stage_valid_ff, stage_valid_in;
   wgm_req_type       stage_ff;
   // matcher state
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [NPOS-1:0]   act_ff, act_in;
   logic              started_ff, started_in;
   logic              ovf_ff, ovf_in;
   logic              cs_ff;
   logic [CHAR_BITS-1:0] store_ff [MAX_PATTERN];
   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   wgm_rsp_type       rsp_ff, rsp_in;

   logic              req_accept;
   logic              advance;
   logic              store_wr;
   logic [CHAR_BITS-1:0] subj_char;
   logic [MAX_PATTERN-1:0] star_eff;
   logic [MAX_PATTERN-1:0] lit_eff;
   logic [NPOS-1:0]   act_base;
   logic [NPOS-1:0]   g, p, gn, pn;
   logic [NPOS-1:0]   cur;
   logic [NPOS-1:0]   nxt;

   // an end of subject may move on only if the result register is free or read out
   assign advance = stage_valid_ff &&
                    (stage_ff.command != CMD_END || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !stage_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   assign subj_char = CHAR_BITS'(stage_ff.char_code);
   assign store_wr  = advance && stage_ff.command == CMD_APPEND &&
                      len_ff < LEN_W'(MAX_PATTERN);

   // per-position decode, masked to the loaded pattern
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         star_eff[i] = (LEN_W'(i) < len_ff) && store_ff[i] == CHAR_BITS'(STAR_CHAR);
         lit_eff[i]  = (LEN_W'(i) < len_ff) && store_ff[i] != CHAR_BITS'(STAR_CHAR) &&
                       (store_ff[i] == CHAR_BITS'(QUEST_CHAR) ||
                        (cs_ff ? store_ff[i] == subj_char
                               : fold_ascii(32'(store_ff[i])) == fold_ascii(32'(subj_char))));
      end
   end

   // star closure: flag j+1 picks up flag j through a star at j (prefix OR)
   always_comb begin
      act_base = started_ff ? act_ff : NPOS'(1);
      g    = act_base;
      p[0] = 1'b0;
      for (int j = 1; j < NPOS; j++) begin
         p[j] = star_eff[j-1];
      end
      gn = g;
      pn = p;
      for (int l = 0; l < LEVELS; l++) begin
         gn = g;
         pn = p;
         for (int j = 0; j < NPOS; j++) begin
            if (j >= (1 << l)) begin
               gn[j] = g[j] | (p[j] & g[j - (1 << l)]);
               pn[j] = p[j] & p[j - (1 << l)];
            end
         end
         g = gn;
         p = pn;
      end
      cur = g;
   end

   // one subject character step
   always_comb begin
      nxt = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (cur[i] && star_eff[i]) begin
            nxt[i] = 1'b1;
         end
         if (cur[i] && lit_eff[i]) begin
            nxt[i+1] = 1'b1;
         end
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      len_in         = len_ff;
      act_in         = act_ff;
      started_in     = started_ff;
      ovf_in         = ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_in         = rsp_ff;
      if (advance) begin
         stage_valid_in = 1'b0;
         case (stage_ff.command)
            CMD_APPEND: begin
               if (store_wr) begin
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_SUBJECT: begin
               act_in     = nxt;
               started_in = 1'b1;
            end
            CMD_END: begin
               rsp_valid_in            = 1'b1;
               rsp_in.matched          = cur[len_ff];
               rsp_in.pattern_overflow = ovf_ff;
               act_in                  = '0;
               started_in              = 1'b0;
            end
            CMD_CLEAR: begin
               len_in     = '0;
               ovf_in     = 1'b0;
               act_in     = '0;
               started_in = 1'b0;
            end
            default: begin
               stage_valid_in = 1'b0;
            end
         endcase
      end
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         len_ff         <= '0;
         act_ff         <= '0;
         started_ff     <= 1'b0;
         ovf_ff         <= 1'b0;
         cs_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         len_ff         <= len_in;
         act_ff         <= act_in;
         started_ff     <= started_in;
         ovf_ff         <= ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_if.valid) begin
            cs_ff <= csr_if.payload.case_sensitive;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= req_if.payload;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[len_ff[IDX_W-1:0]] <= subj_char;
      end
   end

   // ---- assertions ----
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> len_ff == LEN_W'(MAX_PATTERN))
      else $error("overflow flagged with room left in the store");

   a_end_result: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_ff.command == CMD_END) |=> (rsp_valid_ff && !started_ff))
      else $error("end of subject did not produce a result");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_ff.command == CMD_CLEAR) |=>
         (len_ff == '0 && !ovf_ff && !started_ff && act_ff == '0))
      else $error("clear left pattern state behind");

endmodule

[test/tb_wildcard_glob_matcher.sv]
// Self-checking testbench for wildcard_glob_matcher: directed table, then
// random pattern/subject sequences under varying handshake pressure.
// Depends on wgm_pkg, wgm_chan_if and the matcher RTL.
module tb_wildcard_glob_matcher;
   timeunit 1ns;
   timeprecision 1ps;

   import wgm_pkg::*;

   localparam int          PAT_DEPTH = MAX_PATTERN_DEF;
   localparam logic [15:0] CH_STAR   = STAR_CHAR[15:0];
   localparam logic [15:0] CH_QUEST  = QUEST_CHAR[15:0];
   localparam int          HOLD_CYCLES = 200;
   localparam int          SETTLE_CYCLES = 4;

   // letters at both ends of a-z / A-Z and their non-letter neighbors
   localparam logic [15:0] EDGE_CHARS [10] = '{
      16'h0061, 16'h0062, 16'h007A, 16'h0041, 16'h0042,
      16'h005A, 16'h0040, 16'h005B, 16'h0060, 16'h007B
   };

   typedef struct {
      wgm_cmd_type  cmd;
      logic [15:0]  code;
      bit           typed;
      wgm_rsp_type  rsp;   // {matched, pattern_overflow}, used when typed
   } stim_row_type;

   stim_row_type directed_rows [26] = '{
      '{CMD_END,     16'h0000, 1'b1, 2'b10},  // empty pattern, empty subject
      '{CMD_SUBJECT, 16'h0061, 1'b0, 2'b00},
      '{CMD_END,     16'h0000, 1'b1, 2'b00},  // empty pattern, one char
      '{CMD_APPEND,  CH_STAR,  1'b0, 2'b00},
      '{CMD_END,     16'h0000, 1'b1, 2'b10},  // stars only, empty subject
      '{CMD_APPEND,  16'h0061, 1'b0, 2'b00},
      '{CMD_SUBJECT, 16'h0058, 1'b0, 2'b00},
      '{CMD_SUBJECT, 16'h0041, 1'b0, 2'b00},
      '{CMD_END,     16'h0000, 1'b0, 2'b00},
      '{CMD_CLEAR,   16'h0000, 1'b0, 2'b00},
      '{CMD_APPEND,  CH_QUEST, 1'b0, 2'b00},
      '{CMD_APPEND,  16'hFFFF, 1'b0, 2'b00},
      '{CMD_APPEND,  16'h007B, 1'b0, 2'b00},
      '{CMD_SUBJECT, 16'h0000, 1'b0, 2'b00},
      '{CMD_SUBJECT, 16'hFFFF, 1'b0, 2'b00},
      '{CMD_SUBJECT, 16'h005B, 1'b0, 2'b00},
      '{CMD_END,     16'h0000, 1'b0, 2'b00},
      '{CMD_CLEAR,   16'h0000, 1'b0, 2'b00},
      '{CMD_APPEND,  CH_STAR,  1'b0, 2'b00},
      '{CMD_SUBJECT, 16'h0071, 1'b0, 2'b00},
      '{CMD_APPEND,  16'h007A, 1'b0, 2'b00},  // appended mid-subject
      '{CMD_SUBJECT, 16'h005A, 1'b0, 2'b00},
      '{CMD_END,     16'h0000, 1'b0, 2'b00},
      '{CMD_SUBJECT, 16'h006B, 1'b0, 2'b00},
      '{CMD_CLEAR,   16'h0000, 1'b0, 2'b00},  // drops the subject in flight
      '{CMD_END,     16'h0000, 1'b1, 2'b10}
   };

   logic clock;
   logic reset;

   wgm_chan_if #(.payload_type(wgm_req_type)) req_if ();
   wgm_chan_if #(.payload_type(wgm_rsp_type)) rsp_if ();
   wgm_chan_if #(.payload_type(wgm_csr_type)) csr_if ();

   wildcard_glob_matcher uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // matcher state mirror
   logic [15:0] pat_chars [PAT_DEPTH];
   int          pat_len = 0;
   logic [32:0] live_pos = '0;
   bit          subj_on = 1'b0;
   bit          ovf_seen = 1'b0;
   bit          cs_mode = 1'b0;

   wgm_rsp_type pending_verdicts [$];
   int          mismatch_count = 0;

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_req_cnt = 0;
   int hold_ack_cnt = 0;
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [15:0] upcase(input logic [15:0] c);
      if (c >= 16'h0061 && c <= 16'h007A) begin
         return c - 16'h0020;
      end
      return c;
   endfunction

   function automatic bit char_hit(input logic [15:0] p, input logic [15:0] s);
      if (p == CH_QUEST) begin
         return 1'b1;
      end
      if (cs_mode) begin
         return p == s;
      end
      return upcase(p) == upcase(s);
   endfunction

   // advance the mirror by one command; returns 1 when a verdict is produced
   function automatic bit glob_step(input wgm_req_type r, output wgm_rsp_type o);
      logic [32:0] cur;
      logic [32:0] nxt;
      int          n;
      int          i;
      o = '0;
      n = pat_len;
      if (r.command == CMD_APPEND) begin
         if (pat_len < PAT_DEPTH) begin
            pat_chars[pat_len] = r.char_code;
            pat_len++;
         end else begin
            ovf_seen = 1'b1;
         end
         return 1'b0;
      end
      if (r.command == CMD_CLEAR) begin
         pat_len  = 0;
         ovf_seen = 1'b0;
         subj_on  = 1'b0;
         live_pos = '0;
         return 1'b0;
      end
      if (!subj_on) begin
         live_pos = 33'd1;
         subj_on  = 1'b1;
      end
      cur = live_pos;
      for (i = 0; i < n; i++) begin
         if (cur[i] && pat_chars[i] == CH_STAR) cur[i+1] = 1'b1;
      end
      if (r.command == CMD_SUBJECT) begin
         nxt = '0;
         for (i = 0; i < n; i++) begin
            if (cur[i]) begin
               if (pat_chars[i] == CH_STAR) nxt[i] = 1'b1;
               else if (char_hit(pat_chars[i], r.char_code)) nxt[i+1] = 1'b1;
            end
         end
         live_pos = nxt;
         return 1'b0;
      end
      o.matched          = cur[n];
      o.pattern_overflow = ovf_seen;
      subj_on  = 1'b0;
      live_pos = '0;
      return 1'b1;
   endfunction

   function automatic logic [15:0] rand_subj_char();
      int r;
      r = $urandom_range(99);
      if (r < 80) return EDGE_CHARS[$urandom_range(9)];
      if (r < 88) return ($urandom_range(1) != 0) ? CH_STAR : CH_QUEST;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] rand_pat_char();
      int r;
      r = $urandom_range(99);
      if (r < 25) return CH_STAR;
      if (r < 40) return CH_QUEST;
      return rand_subj_char();
   endfunction

   task automatic push_cmd(input wgm_cmd_type c, input logic [15:0] code,
                           input bit typed, input wgm_rsp_type typed_rsp);
      wgm_req_type r;
      wgm_rsp_type v;
      bit          got;
      r.command   = c;
      r.char_code = code;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      got = glob_step(r, v);
      if (got) pending_verdicts.push_back(typed ? typed_rsp : v);
   endtask

   task automatic drain_and_settle();
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      // appends and clears leave no result behind to wait for
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_case_mode(input bit mode);
      wgm_csr_type w;
      w.case_sensitive = mode;
      csr_if.valid   <= 1'b1;
      csr_if.payload <= w;
      do @(posedge clock); while (!csr_if.ready);
      cs_mode = mode;
      csr_if.valid <= 1'b0;
   endtask

   // mostly well-formed pattern + subject + end, with some noise commands
   task automatic random_phase(input int quota);
      int          sent;
      int          plen;
      int          r;
      logic [15:0] ch;
      logic [15:0] pat [$];
      logic [15:0] subj [$];
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(99) < 12) begin
            push_cmd(wgm_cmd_type'($urandom_range(3)), 16'($urandom), 1'b0, '0);
            sent++;
         end else begin
            if ($urandom_range(1) != 0) begin
               push_cmd(CMD_CLEAR, 16'($urandom), 1'b0, '0);
               sent++;
            end
            r = $urandom_range(99);
            if (r < 70) plen = $urandom_range(5);
            else if (r < 93) plen = $urandom_range(12, 6);
            else plen = $urandom_range(36, 28);
            pat.delete();
            repeat (plen) begin
               ch = rand_pat_char();
               pat.push_back(ch);
               push_cmd(CMD_APPEND, ch, 1'b0, '0);
               sent++;
            end
            // subject that tends to match what was just appended
            subj.delete();
            foreach (pat[k]) begin
               if (pat[k] == CH_STAR) begin
                  repeat ($urandom_range(2)) subj.push_back(rand_subj_char());
               end else if (pat[k] == CH_QUEST) begin
                  subj.push_back(rand_subj_char());
               end else if (pat[k] >= 16'h0040 && pat[k] <= 16'h007F &&
                            $urandom_range(1) != 0) begin
                  subj.push_back(pat[k] ^ 16'h0020);
               end else begin
                  subj.push_back(pat[k]);
               end
            end
            if (subj.size() != 0 && $urandom_range(99) < 30)
               subj[$urandom_range(subj.size() - 1)] = rand_subj_char();
            if ($urandom_range(99) < 10) subj.push_back(rand_subj_char());
            foreach (subj[k]) begin
               if ($urandom_range(99) < 4) begin
                  push_cmd(CMD_APPEND, rand_pat_char(), 1'b0, '0);
                  sent++;
               end
               push_cmd(CMD_SUBJECT, subj[k], 1'b0, '0);
               sent++;
            end
            push_cmd(CMD_END, 16'($urandom), 1'b0, '0);
            sent++;
         end
      end
   endtask

   // result side backpressure; long hold-offs are counted here
   always @(posedge clock) begin
      if (hold_ack_cnt != hold_req_cnt) begin
         hold_ack_cnt = hold_req_cnt;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      wgm_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: matched=%0b overflow=%0b",
                        rsp_if.payload.matched, rsp_if.payload.pattern_overflow);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_if.payload.matched !== want.matched ||
                rsp_if.payload.pattern_overflow !== want.pattern_overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected matched=%0b overflow=%0b, got %0b %0b",
                           want.matched, want.pattern_overflow,
                           rsp_if.payload.matched, rsp_if.payload.pattern_overflow);
            end
         end
      end
   end

   initial begin
      int i;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < $size(directed_rows); i++) begin
         push_cmd(directed_rows[i].cmd, directed_rows[i].code,
                  directed_rows[i].typed, directed_rows[i].rsp);
      end
      drain_and_settle();

      write_case_mode(1'b1);
      random_phase(140);
      drain_and_settle();

      write_case_mode(1'b0);
      idle_pct = 72;
      random_phase(140);

      // overflow the store, then keep offering work while results back up
      idle_pct  = 0;
      stall_pct = 0;
      hold_req_cnt++;
      push_cmd(CMD_CLEAR, 16'h0000, 1'b0, '0);
      repeat (PAT_DEPTH + 2) push_cmd(CMD_APPEND, rand_pat_char(), 1'b0, '0);
      repeat (8) begin
         repeat (2) push_cmd(CMD_SUBJECT, rand_subj_char(), 1'b0, '0);
         push_cmd(CMD_END, 16'h0000, 1'b0, '0);
      end
      drain_and_settle();

      write_case_mode(1'b1);
      stall_pct = 72;
      random_phase(140);
      drain_and_settle();

      write_case_mode(1'b0);
      idle_pct  = 14;
      stall_pct = 14;
      random_phase(140);

      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
